### rtl/core/spq4_pkg.sv
// shared types and constants for the strict priority four class queue
package spq4_pkg;

    localparam int CLASS_COUNT = 4;
    localparam int CLASS_W     = 2;
    localparam int TICKET_W    = 16;
    localparam int MOD_W       = 11;
    localparam int WAIT_W      = 12;
    localparam int COUNT_W     = 7;
    localparam int PEAK_W      = 9;
    localparam int SERVED_W    = 32;
    localparam int MAXW_W      = 11;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] OP_ARRIVE = 2'd0;
    localparam logic [1:0] OP_SERVE  = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;

    localparam logic [1:0] KIND_ARRIVE = 2'd0;
    localparam logic [1:0] KIND_SERVE  = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] ticket;
        logic [2:0]  class_code;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } t_in_word;

    typedef struct packed {
        logic                     served;
        logic                     rejected;
        logic [TICKET_W-1:0]      ticket_out;
        logic [CLASS_W-1:0]       class_out;
        logic signed [WAIT_W-1:0] wait_minutes;
        logic [COUNT_W-1:0]       count_class0;
        logic [COUNT_W-1:0]       count_class1;
        logic [COUNT_W-1:0]       count_class2;
        logic [COUNT_W-1:0]       count_class3;
        logic [SERVED_W-1:0]      served_total;
        logic [PEAK_W-1:0]        peak_total;
        logic [MAXW_W-1:0]        max_wait;
    } t_out_word;

    typedef struct packed {
        logic [TICKET_W-1:0] ticket;
        logic [MOD_W-1:0]    mod;
    } t_slot;

    typedef struct packed {
        logic [1:0]          kind;
        logic [CLASS_W-1:0]  cls;
        logic [TICKET_W-1:0] ticket;
        logic [MOD_W-1:0]    mod;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

### rtl/core/spq4_front.sv
// front end: accepts input words and turns them into queue commands
module spq4_front (
    input  logic                    i_in_valid,
    input  spq4_pkg::t_in_word      i_in_word,
    input  spq4_pkg::t_fifo_status  i_fifo_status,
    output logic                    o_in_stall,
    output logic                    o_push,
    output spq4_pkg::t_cmd          o_cmd
);
    import spq4_pkg::*;

    logic [MOD_W-1:0] now_mod;

    // hour * 60 + minute as 64h - 4h + minute
    assign now_mod = (MOD_W'(i_in_word.hour) << 6) - (MOD_W'(i_in_word.hour) << 2)
                   + MOD_W'(i_in_word.minute);

    assign o_in_stall = i_fifo_status.full;
    assign o_push     = i_in_valid && !i_fifo_status.full;

    always_comb begin
        o_cmd.cls    = i_in_word.class_code[CLASS_W-1:0];
        o_cmd.ticket = i_in_word.ticket;
        o_cmd.mod    = now_mod;
        case (i_in_word.op)
            OP_ARRIVE: begin
                // an arrival with a class above three becomes a report and changes nothing
                o_cmd.kind = i_in_word.class_code[2] ? KIND_REPORT : KIND_ARRIVE;
            end
            OP_SERVE: begin
                o_cmd.kind = KIND_SERVE;
            end
            default: begin
                o_cmd.kind = KIND_REPORT;
            end
        endcase
    end

endmodule

### rtl/core/spq4_cmd_fifo.sv
// short command queue between front end and back end
module spq4_cmd_fifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  spq4_pkg::t_cmd          i_cmd,
    input  logic                    i_pop,
    output spq4_pkg::t_cmd          o_cmd,
    output spq4_pkg::t_fifo_status  o_status
);
    import spq4_pkg::*;

    t_cmd                  r_data [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + FIFO_CNT_W'(1);
                2'b01:   r_count <= r_count - FIFO_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_cmd          = r_data[r_rd_ptr];
    assign o_status.full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

### rtl/core/spq4_back.sv
// back end: class queues in memory, counters and output register
module spq4_back #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  spq4_pkg::t_cmd          i_cmd,
    input  spq4_pkg::t_fifo_status  i_fifo_status,
    output logic                    o_pop,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output spq4_pkg::t_out_word     o_out_word
);
    import spq4_pkg::*;

    localparam int PW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int SW        = CW + 1;
    localparam int TW        = $clog2(CLASS_COUNT * QUEUE_DEPTH + 1);
    localparam int AW        = PW + CLASS_W;
    localparam int MEM_DEPTH = 1 << AW;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    t_slot r_mem [MEM_DEPTH];

    logic                r_state, n_state;
    logic [PW-1:0]       r_head [CLASS_COUNT];
    logic [PW-1:0]       n_head [CLASS_COUNT];
    logic [CW-1:0]       r_fill [CLASS_COUNT];
    logic [CW-1:0]       n_fill [CLASS_COUNT];
    logic [TW-1:0]       r_total, n_total;
    logic [TW-1:0]       r_peak, n_peak;
    logic [SERVED_W-1:0] r_served_cnt, n_served_cnt;
    logic [MAXW_W-1:0]   r_long, n_long;
    logic [CLASS_W-1:0]  r_sel, n_sel;
    logic [MOD_W-1:0]    r_now, n_now;
    t_slot               r_rd_data;
    logic                r_out_valid, n_out_valid;
    t_out_word           r_out, n_out;

    logic                out_free;
    logic                any_ready;
    logic [CLASS_W-1:0]  sel;
    logic                arrive_ok;
    logic [SW-1:0]       tail_sum;
    logic [PW-1:0]       tail;
    logic                do_write;
    logic                do_read;
    logic [WAIT_W-1:0]   wait_val;
    logic                load;
    logic                res_served;
    logic                res_rej;
    logic [TICKET_W-1:0] res_ticket;
    logic [CLASS_W-1:0]  res_cls;
    logic [WAIT_W-1:0]   res_wait;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == ST_IDLE) && !i_fifo_status.empty && out_free;

    // lowest-numbered non-empty class; class 0 has the highest priority
    always_comb begin
        any_ready = 1'b0;
        sel       = '0;
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
            if (r_fill[c] != '0) begin
                any_ready = 1'b1;
                sel       = CLASS_W'(c);
            end
        end
    end

    assign arrive_ok = (r_fill[i_cmd.cls] != CW'(QUEUE_DEPTH));
    assign tail_sum  = SW'(r_head[i_cmd.cls]) + SW'(r_fill[i_cmd.cls]);
    assign tail      = (tail_sum >= SW'(QUEUE_DEPTH)) ? PW'(tail_sum - SW'(QUEUE_DEPTH))
                                                      : PW'(tail_sum);
    assign do_write  = o_pop && (i_cmd.kind == KIND_ARRIVE) && arrive_ok;
    assign do_read   = o_pop && (i_cmd.kind == KIND_SERVE) && any_ready;
    assign wait_val  = {1'b0, r_now} - {1'b0, r_rd_data.mod};

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[{i_cmd.cls, tail}] <= '{ticket: i_cmd.ticket, mod: i_cmd.mod};
        end
        if (do_read) begin
            r_rd_data <= r_mem[{sel, r_head[sel]}];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_fill       = r_fill;
        n_total      = r_total;
        n_peak       = r_peak;
        n_served_cnt = r_served_cnt;
        n_long       = r_long;
        n_sel        = r_sel;
        n_now        = r_now;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        load         = 1'b0;
        res_served   = 1'b0;
        res_rej      = 1'b0;
        res_ticket   = '0;
        res_cls      = '0;
        res_wait     = '0;

        if (o_pop) begin
            case (i_cmd.kind)
                KIND_ARRIVE: begin
                    load = 1'b1;
                    if (!arrive_ok) begin
                        res_rej = 1'b1;
                    end else begin
                        n_fill[i_cmd.cls] = r_fill[i_cmd.cls] + CW'(1);
                        n_total           = r_total + TW'(1);
                        if (n_total > r_peak) begin
                            n_peak = n_total;
                        end
                    end
                end
                KIND_SERVE: begin
                    if (any_ready) begin
                        n_state = ST_READ;
                        n_sel   = sel;
                        n_now   = i_cmd.mod;
                    end else begin
                        load = 1'b1;
                    end
                end
                default: begin
                    load = 1'b1;
                end
            endcase
        end

        if (r_state == ST_READ && out_free) begin
            load          = 1'b1;
            n_state       = ST_IDLE;
            res_served    = 1'b1;
            res_ticket    = r_rd_data.ticket;
            res_cls       = r_sel;
            res_wait      = wait_val;
            n_head[r_sel] = (r_head[r_sel] == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                    : r_head[r_sel] + PW'(1);
            n_fill[r_sel] = r_fill[r_sel] - CW'(1);
            n_total       = r_total - TW'(1);
            if (r_served_cnt != '1) begin
                n_served_cnt = r_served_cnt + SERVED_W'(1);
            end
            if (!wait_val[WAIT_W-1] && wait_val != '0
                    && wait_val[MAXW_W-1:0] > r_long) begin
                n_long = wait_val[MAXW_W-1:0];
            end
        end

        if (load) begin
            n_out_valid        = 1'b1;
            n_out.served       = res_served;
            n_out.rejected     = res_rej;
            n_out.ticket_out   = res_ticket;
            n_out.class_out    = res_cls;
            n_out.wait_minutes = res_wait;
            n_out.count_class0 = COUNT_W'(n_fill[0]);
            n_out.count_class1 = COUNT_W'(n_fill[1]);
            n_out.count_class2 = COUNT_W'(n_fill[2]);
            n_out.count_class3 = COUNT_W'(n_fill[3]);
            n_out.served_total = n_served_cnt;
            n_out.peak_total   = PEAK_W'(n_peak);
            n_out.max_wait     = n_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_total      <= '0;
            r_peak       <= '0;
            r_served_cnt <= '0;
            r_long       <= '0;
            r_out_valid  <= 1'b0;
            for (int c = 0; c < CLASS_COUNT; c++) begin
                r_head[c] <= '0;
                r_fill[c] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_total      <= n_total;
            r_peak       <= n_peak;
            r_served_cnt <= n_served_cnt;
            r_long       <= n_long;
            r_out_valid  <= n_out_valid;
            r_head       <= n_head;
            r_fill       <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel <= n_sel;
        r_now <= n_now;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

### rtl/core/strict_priority_four_class_queue.sv
// top level of the strict priority four class queue
// Arrive, serve and report words enter through a two-word command queue, so the input side
// keeps taking words until that queue is full, while the back end works or the output is
// stalled. In the back end an arrival or a report loads the output register when popped; a
// serve of a non-empty class first passes ST_READ, the registered read of the head entry
// from the single-port class memory. Four classes of QUEUE_DEPTH entries each share that
// memory; it needs no clearing pass after reset, so words are taken once reset is released.
// Arrivals to a full class are dropped as rejected; class codes above three change nothing.
module strict_priority_four_class_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  spq4_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output spq4_pkg::t_out_word  o_out_word
);
    import spq4_pkg::*;

    logic         push;
    logic         pop;
    t_cmd         front_cmd;
    t_cmd         back_cmd;
    t_fifo_status fifo_status;

    spq4_front u_front (
        .i_in_valid    (i_in_valid),
        .i_in_word     (i_in_word),
        .i_fifo_status (fifo_status),
        .o_in_stall    (o_in_stall),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    spq4_cmd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (back_cmd),
        .o_status (fifo_status)
    );

    spq4_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (back_cmd),
        .i_fifo_status (fifo_status),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_word    (o_out_word)
    );

    a_serve_rejected_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.served && o_out_word.rejected))
        else $error("word both served and rejected");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.served) |->
        (o_out_word.ticket_out == '0 && o_out_word.class_out == '0
         && o_out_word.wait_minutes == '0))
        else $error("entry fields set on a word that served nothing");

    a_served_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.served) |-> (o_out_word.served_total != '0))
        else $error("served word with zero served total");

    a_max_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.served && !o_out_word.wait_minutes[WAIT_W-1]) |->
        (o_out_word.max_wait >= o_out_word.wait_minutes[MAXW_W-1:0]))
        else $error("longest wait below the wait just served");

    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !fifo_status.empty && !push || !fifo_status.empty)
        else $error("command popped from an empty queue");

endmodule

### bench/strict_priority_four_class_queue_tb.sv
// self-checking testbench for the strict priority four class queue
module strict_priority_four_class_queue_tb;
    import spq4_pkg::*;

    localparam int          DEPTH       = 64;
    localparam int          HOLD_CYCLES = 400;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          PHASE_ITEMS = 200;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    class class_queue_tracker;
        t_slot          lanes[CLASS_COUNT][$];
        t_out_word      awaited_results[$];
        logic [31:0]    served_cnt;
        int             peak_fill;
        int             longest_wait;
        int             mismatches;
        int             words_in;
        int             words_out;
        int             pops;
        int             drops;
        int             negative_waits;

        function new();
            served_cnt     = '0;
            peak_fill      = 0;
            longest_wait   = 0;
            mismatches     = 0;
            words_in       = 0;
            words_out      = 0;
            pops           = 0;
            drops          = 0;
            negative_waits = 0;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void note_accepted(t_in_word w);
            t_out_word  e;
            t_slot      s;
            int         now;
            int         wv;
            int         total;
            bit         hit;
            e     = '0;
            hit   = 1'b0;
            now   = int'(w.hour) * 60 + int'(w.minute);
            words_in++;
            case (w.op)
                OP_ARRIVE: begin
                    if (w.class_code < CLASS_COUNT) begin
                        if (lanes[w.class_code].size() >= DEPTH) begin
                            e.rejected = 1'b1;
                            drops++;
                        end else begin
                            s.ticket = w.ticket;
                            s.mod    = now[MOD_W-1:0];
                            lanes[w.class_code].push_back(s);
                            total = 0;
                            for (int c = 0; c < CLASS_COUNT; c++) total += lanes[c].size();
                            if (total > peak_fill) peak_fill = total;
                        end
                    end
                end
                OP_SERVE: begin
                    for (int c = 0; c < CLASS_COUNT && !hit; c++) begin
                        if (lanes[c].size() != 0) begin
                            hit            = 1'b1;
                            s              = lanes[c].pop_front();
                            wv             = now - int'(s.mod);
                            e.served       = 1'b1;
                            e.ticket_out   = s.ticket;
                            e.class_out    = c[CLASS_W-1:0];
                            e.wait_minutes = wv[WAIT_W-1:0];
                            if (served_cnt != '1) served_cnt++;
                            if (wv > longest_wait) longest_wait = wv;
                            if (wv < 0) negative_waits++;
                            pops++;
                        end
                    end
                end
                default: ;
            endcase
            e.count_class0 = COUNT_W'(lanes[0].size());
            e.count_class1 = COUNT_W'(lanes[1].size());
            e.count_class2 = COUNT_W'(lanes[2].size());
            e.count_class3 = COUNT_W'(lanes[3].size());
            e.served_total = served_cnt;
            e.peak_total   = peak_fill[PEAK_W-1:0];
            e.max_wait     = longest_wait[MAXW_W-1:0];
            awaited_results.push_back(e);
        endfunction

        function void compare_field(string fname, longint want, longint got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at result %0d, %s: expected %0d, got %0d",
                             words_out, fname, want, got);
            end
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing expected: %h", got);
                return;
            end
            want = awaited_results.pop_front();
            compare_field("served",       want.served,       got.served);
            compare_field("rejected",     want.rejected,     got.rejected);
            compare_field("ticket_out",   want.ticket_out,   got.ticket_out);
            compare_field("class_out",    want.class_out,    got.class_out);
            compare_field("wait_minutes", want.wait_minutes, got.wait_minutes);
            compare_field("count_class0", want.count_class0, got.count_class0);
            compare_field("count_class1", want.count_class1, got.count_class1);
            compare_field("count_class2", want.count_class2, got.count_class2);
            compare_field("count_class3", want.count_class3, got.count_class3);
            compare_field("served_total", want.served_total, got.served_total);
            compare_field("peak_total",   want.peak_total,   got.peak_total);
            compare_field("max_wait",     want.max_wait,     got.max_wait);
            words_out++;
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_word;

    class_queue_tracker board = new();
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   cycle_count   = 0;
    logic hold_now      = 1'b0;
    event hold_kick;

    strict_priority_four_class_queue #(.QUEUE_DEPTH(DEPTH)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // output side: check each taken word, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_word);
        i_out_stall <= hold_now || ($urandom_range(0, 99) < recv_idle_pct);
    end

    initial begin
        @(hold_kick);
        @(posedge i_clk);
        hold_now <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_now <= 1'b0;
    end

    function automatic t_in_word build_word(logic [1:0] op, logic [15:0] ticket,
                                            logic [2:0] cls, logic [4:0] hour,
                                            logic [5:0] minute);
        t_in_word w;
        w.op         = op;
        w.ticket     = ticket;
        w.class_code = cls;
        w.hour       = hour;
        w.minute     = minute;
        return w;
    endfunction

    function automatic t_in_word random_word(logic [1:0] op, int cls);
        return build_word(op, 16'($urandom_range(0, 65535)), cls[2:0],
                          5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
    endfunction

    task automatic send_word(t_in_word w);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        board.note_accepted(w);
    endtask

    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    task automatic run_directed();
        send_word(build_word(OP_SERVE,  16'h0000, 3'd0, 5'd0,  6'd0));
        send_word(build_word(OP_REPORT, 16'hffff, 3'd7, 5'd31, 6'd63));
        send_word(build_word(OP_UNUSED, 16'hffff, 3'd0, 5'd31, 6'd63));
        send_word(build_word(OP_ARRIVE, 16'hffff, 3'd4, 5'd31, 6'd63));
        send_word(build_word(OP_ARRIVE, 16'h5a5a, 3'd7, 5'd0,  6'd0));
        send_word(build_word(OP_ARRIVE, 16'h0000, 3'd3, 5'd0,  6'd0));
        send_word(build_word(OP_ARRIVE, 16'hffff, 3'd2, 5'd31, 6'd63));
        send_word(build_word(OP_ARRIVE, 16'h1234, 3'd1, 5'd10, 6'd30));
        send_word(build_word(OP_ARRIVE, 16'habcd, 3'd0, 5'd12, 6'd0));
        send_word(build_word(OP_SERVE,  16'h0000, 3'd5, 5'd23, 6'd59));
        send_word(build_word(OP_SERVE,  16'h0000, 3'd0, 5'd0,  6'd0));
        send_word(build_word(OP_SERVE,  16'h0000, 3'd0, 5'd31, 6'd63));
        send_word(build_word(OP_SERVE,  16'h0000, 3'd0, 5'd31, 6'd63));
        send_word(build_word(OP_SERVE,  16'h0000, 3'd0, 5'd12, 6'd0));
        send_word(build_word(OP_REPORT, 16'h0000, 3'd0, 5'd0,  6'd0));
        send_word(build_word(OP_ARRIVE, 16'h8001, 3'd0, 5'd31, 6'd63));
        send_word(build_word(OP_SERVE,  16'h0000, 3'd0, 5'd0,  6'd0));
        send_word(build_word(OP_REPORT, 16'h0000, 3'd0, 5'd0,  6'd0));
    endtask

    task automatic run_random(int n);
        t_in_word   w;
        int         counted;
        int         len;
        int         r;
        int         cls;
        counted = 0;
        while (counted < n) begin
            r   = $urandom_range(0, 99);
            len = $urandom_range(1, 12);
            cls = $urandom_range(0, 3);
            if (r < 6) len = $urandom_range(64, 72);
            for (int k = 0; k < len; k++) begin
                if (r < 40)
                    w = random_word(OP_ARRIVE, cls);
                else if (r < 65)
                    w = random_word(OP_SERVE, $urandom_range(0, 7));
                else if (r < 85)
                    w = random_word((k % 2) ? OP_SERVE : OP_ARRIVE, $urandom_range(0, 3));
                else
                    w = random_word(2'($urandom_range(0, 3)), $urandom_range(0, 7));
                send_word(w);
                if (!(w.op == OP_ARRIVE && w.class_code >= CLASS_COUNT)) counted++;
            end
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        send_idle_pct = 20;
        recv_idle_pct = 64;
        run_random(PHASE_ITEMS);
        pause_until_drained();

        send_idle_pct = 64;
        recv_idle_pct = 20;
        run_random(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        -> hold_kick;
        run_random(PHASE_ITEMS);

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        repeat (10) @(posedge i_clk);

        $display("ran %0d words in and %0d results out over %0d cycles",
                 board.words_in, board.words_out, cycle_count);
        $display("%0d pops, %0d full-class drops, %0d negative waits, peak fill %0d",
                 board.pops, board.drops, board.negative_waits, board.peak_fill);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
